// ----- rtl/blt_pkg.sv -----
// ----------------------------------------------------------------------------
// blt_pkg
// Shared types and constants of the clipped, keyed and tinted blitter core.
// ----------------------------------------------------------------------------
package blt_pkg;

	localparam int DIM_W        = 13;
	localparam int COORD_W      = 16;
	localparam int POS_W        = 18;
	localparam int ADDR_W       = 24;
	localparam int COLOR_W      = 32;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;
	localparam int CH_W         = 8;
	localparam int TINT_BIT     = 1;

	localparam int DEF_MAX_SURFACE_DIM = 4096;
	localparam int DEF_QUEUE_DEPTH     = 2;

	localparam logic [DIM_W-1:0]   RST_SURF_W = 13'd320;
	localparam logic [DIM_W-1:0]   RST_SURF_H = 13'd240;
	localparam logic [COLOR_W-1:0] RST_TINT   = 32'hffff_ffff;
	localparam logic [CH_W-1:0]    CH_MASK    = 8'hff;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	typedef enum logic [1:0] {
		MODE_COPY = 2'd0,
		MODE_KEY  = 2'd1,
		MODE_TINT = 2'd2
	} blt_mode_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SURF_W = 3'd0,
		CFG_SURF_H = 3'd1,
		CFG_MODE   = 3'd2,
		CFG_KEY    = 3'd3,
		CFG_TINT   = 3'd4
	} blt_cfg_e;

	// classified pixel handed from front to back
	typedef struct packed {
		logic               excess;
		logic               on_surf;
		logic               last;
		logic [DIM_W-1:0]   col_x;
		logic [ADDR_W-1:0]  row_base;
		logic [COLOR_W-1:0] src;
	} blt_pix_t;

endpackage

// ----- rtl/blt_in_if.sv -----
// ----------------------------------------------------------------------------
// blt_in_if
// Input item channel: start items and source pixels.
// ----------------------------------------------------------------------------
interface blt_in_if
	import blt_pkg::*;
;
	logic                      valid;
	logic                      ready;
	logic                      cmd;
	logic signed [COORD_W-1:0] origin_x;
	logic signed [COORD_W-1:0] origin_y;
	logic [DIM_W-1:0]          region_width;
	logic [DIM_W-1:0]          region_height;
	logic [COLOR_W-1:0]        source_pixel;

	modport source (
		output valid, cmd, origin_x, origin_y, region_width, region_height, source_pixel,
		input  ready
	);
	modport sink (
		input  valid, cmd, origin_x, origin_y, region_width, region_height, source_pixel,
		output ready
	);
endinterface

// ----- rtl/blt_out_if.sv -----
// ----------------------------------------------------------------------------
// blt_out_if
// Result item channel: destination pixel writes.
// ----------------------------------------------------------------------------
interface blt_out_if
	import blt_pkg::*;
;
	logic               valid;
	logic               ready;
	logic               write_enable;
	logic [ADDR_W-1:0]  dest_address;
	logic [COLOR_W-1:0] dest_color;
	logic               region_done;
	logic               excess_pixel;

	modport source (
		output valid, write_enable, dest_address, dest_color, region_done, excess_pixel,
		input  ready
	);
	modport sink (
		input  valid, write_enable, dest_address, dest_color, region_done, excess_pixel,
		output ready
	);
endinterface

// ----- rtl/blt_fe.sv -----
// ----------------------------------------------------------------------------
// blt_fe
// Front end: accepts items, tracks the raster cursor, clips each pixel and
// keeps the destination row base address.
// ----------------------------------------------------------------------------
module blt_fe
	import blt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	blt_in_if.sink            req,
	input  logic [DIM_W-1:0]  eff_w,
	input  logic [DIM_W-1:0]  eff_h,
	input  logic              q_full,
	output logic              q_push,
	output blt_pix_t          q_item
);

	logic                    active_q;
	logic [COORD_W-1:0]      base_x_q;
	logic [COORD_W-1:0]      base_y_q;
	logic [DIM_W-1:0]        span_w_q;
	logic [DIM_W-1:0]        span_h_q;
	logic [DIM_W-1:0]        col_q;
	logic [DIM_W-1:0]        row_q;
	logic signed [POS_W-1:0] y_q;
	logic [ADDR_W-1:0]       row_base_q;

	logic                    take;
	logic                    is_start;
	logic                    is_pixel;
	logic signed [POS_W-1:0] x;
	logic                    on_surf;
	logic                    col_end;
	logic                    row_end;
	logic signed [POS_W-1:0] y_next;
	logic [ADDR_W-1:0]       y_ext;
	logic [ADDR_W+DIM_W-1:0] prod;

	assign req.ready = !q_full;
	assign take      = req.valid && req.ready;
	assign is_start  = take && (req.cmd == CMD_START);
	assign is_pixel  = take && (req.cmd == CMD_PIXEL);

	assign x = POS_W'(signed'(base_x_q)) + POS_W'(col_q);
	assign on_surf = !x[POS_W-1] && !y_q[POS_W-1]
		&& (x[POS_W-2:0] < (POS_W-1)'(eff_w))
		&& (y_q[POS_W-2:0] < (POS_W-1)'(eff_h));

	assign col_end = ((DIM_W+1)'(col_q) + (DIM_W+1)'(1)) >= (DIM_W+1)'(span_w_q);
	assign row_end = ((DIM_W+1)'(row_q) + (DIM_W+1)'(1)) >= (DIM_W+1)'(span_h_q);

	always_comb begin
		if (is_start) begin
			y_next = POS_W'(req.origin_y);
		end else if (row_end) begin
			y_next = POS_W'(signed'(base_y_q));
		end else begin
			y_next = y_q + POS_W'(1);
		end
	end

	assign y_ext = ADDR_W'(y_next);
	assign prod  = (ADDR_W+DIM_W)'(y_ext) * (ADDR_W+DIM_W)'(eff_w);

	assign q_push          = is_pixel;
	assign q_item.excess   = !active_q;
	assign q_item.on_surf  = active_q && on_surf;
	assign q_item.last     = active_q && col_end && row_end;
	assign q_item.col_x    = x[DIM_W-1:0];
	assign q_item.row_base = row_base_q;
	assign q_item.src      = req.source_pixel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			base_x_q   <= '0;
			base_y_q   <= '0;
			span_w_q   <= '0;
			span_h_q   <= '0;
			col_q      <= '0;
			row_q      <= '0;
			y_q        <= '0;
			row_base_q <= '0;
		end else if (is_start) begin
			base_x_q   <= req.origin_x;
			base_y_q   <= req.origin_y;
			span_w_q   <= req.region_width;
			span_h_q   <= req.region_height;
			col_q      <= '0;
			row_q      <= '0;
			y_q        <= y_next;
			row_base_q <= prod[ADDR_W-1:0];
			active_q   <= (req.region_width != '0) && (req.region_height != '0);
		end else if (is_pixel && active_q) begin
			if (col_end) begin
				col_q      <= '0;
				y_q        <= y_next;
				row_base_q <= prod[ADDR_W-1:0];
				if (row_end) begin
					row_q    <= '0;
					active_q <= 1'b0;
				end else begin
					row_q <= row_q + DIM_W'(1);
				end
			end else begin
				col_q <= col_q + DIM_W'(1);
			end
		end
	end

endmodule

// ----- rtl/blt_fifo.sv -----
// ----------------------------------------------------------------------------
// blt_fifo
// Short queue of classified pixels between front and back end.
// ----------------------------------------------------------------------------
module blt_fifo
	import blt_pkg::*;
#(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  blt_pix_t push_item,
	input  logic     pop,
	output blt_pix_t pop_item,
	output logic     full,
	output logic     empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	blt_pix_t           mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/blt_be.sv -----
// ----------------------------------------------------------------------------
// blt_be
// Back end: color key, tint and destination address, into the output register.
// ----------------------------------------------------------------------------
module blt_be
	import blt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  blt_pix_t           q_item,
	output logic               q_pop,
	input  logic [1:0]         mode,
	input  logic [COLOR_W-1:0] key,
	input  logic [COLOR_W-1:0] tint,
	blt_out_if.source          rsp
);

	logic                  valid_q;
	logic                  we_q;
	logic [ADDR_W-1:0]     addr_q;
	logic [COLOR_W-1:0]    color_q;
	logic                  done_q;
	logic                  excess_q;

	logic                  load;
	logic [2*CH_W-1:0]     prod_r;
	logic [2*CH_W-1:0]     prod_g;
	logic [2*CH_W-1:0]     prod_b;
	logic [COLOR_W-1:0]    tinted;
	logic [COLOR_W-1:0]    color;
	logic                  keyed;
	logic [ADDR_W-1:0]     addr;

	assign load  = !q_empty && (!valid_q || rsp.ready);
	assign q_pop = load;

	assign prod_r = (2*CH_W)'(q_item.src[23:16]) * (2*CH_W)'(tint[23:16]);
	assign prod_g = (2*CH_W)'(q_item.src[15:8])  * (2*CH_W)'(tint[15:8]);
	assign prod_b = (2*CH_W)'(q_item.src[7:0])   * (2*CH_W)'(tint[7:0]);
	assign tinted = {q_item.src[31:24], prod_r[2*CH_W-1:CH_W] & CH_MASK,
		prod_g[2*CH_W-1:CH_W] & CH_MASK, prod_b[2*CH_W-1:CH_W] & CH_MASK};

	assign color = mode[TINT_BIT] ? tinted : q_item.src;
	assign keyed = (mode != MODE_COPY) && (q_item.src == key);
	assign addr  = q_item.row_base + ADDR_W'(q_item.col_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (q_item.excess) begin
				we_q     <= 1'b0;
				addr_q   <= '0;
				color_q  <= '0;
				done_q   <= 1'b0;
				excess_q <= 1'b1;
			end else begin
				we_q     <= q_item.on_surf && !keyed;
				addr_q   <= q_item.on_surf ? addr : '0;
				color_q  <= color;
				done_q   <= q_item.last;
				excess_q <= 1'b0;
			end
		end
	end

	assign rsp.valid        = valid_q;
	assign rsp.write_enable = we_q;
	assign rsp.dest_address = addr_q;
	assign rsp.dest_color   = color_q;
	assign rsp.region_done  = done_q;
	assign rsp.excess_pixel = excess_q;

endmodule

// ----- rtl/clipped_keyed_tinted_blitter_core.sv -----
// ----------------------------------------------------------------------------
// clipped_keyed_tinted_blitter_core
// Blitter pixel engine: clips region pixels to the destination surface,
// applies color key and tint, and emits destination writes.
// ----------------------------------------------------------------------------
//  channel  dir  handshake        carries
//  req      in   valid/ready      start geometry or one source pixel
//  rsp      out  valid/ready      write enable, address, color, flags
//  cfg      in   cfg_we strobe    surface size, mode, key, tint
//
//  One item per clock while rsp is ready; each pixel is queued, then registered.
//  The row base multiply is done in the accepting cycle at each row advance.
//  A two-entry queue and the output register decouple req from rsp stalls.
//  arst_n clears cursor, queue and valid state and restores register defaults.
// ----------------------------------------------------------------------------
module clipped_keyed_tinted_blitter_core
	import blt_pkg::*;
#(
	parameter int MAX_SURFACE_DIM = DEF_MAX_SURFACE_DIM,
	parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	blt_in_if.sink                req,
	blt_out_if.source             rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(MAX_SURFACE_DIM);

	logic [DIM_W-1:0]   surf_w_q;
	logic [DIM_W-1:0]   surf_h_q;
	logic [1:0]         mode_q;
	logic [COLOR_W-1:0] key_q;
	logic [COLOR_W-1:0] tint_q;

	logic [DIM_W-1:0]   eff_w;
	logic [DIM_W-1:0]   eff_h;
	logic               q_full;
	logic               q_empty;
	logic               q_push;
	logic               q_pop;
	blt_pix_t           push_item;
	blt_pix_t           pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			surf_w_q <= RST_SURF_W;
			surf_h_q <= RST_SURF_H;
			mode_q   <= MODE_COPY;
			key_q    <= '0;
			tint_q   <= RST_TINT;
		end else if (cfg_we) begin
			case (blt_cfg_e'(cfg_index))
				CFG_SURF_W: surf_w_q <= cfg_data[DIM_W-1:0];
				CFG_SURF_H: surf_h_q <= cfg_data[DIM_W-1:0];
				CFG_MODE:   mode_q   <= cfg_data[1:0];
				CFG_KEY:    key_q    <= cfg_data[COLOR_W-1:0];
				CFG_TINT:   tint_q   <= cfg_data[COLOR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign eff_w = (surf_w_q > MAX_DIM) ? MAX_DIM : surf_w_q;
	assign eff_h = (surf_h_q > MAX_DIM) ? MAX_DIM : surf_h_q;

	blt_fe u_fe (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.eff_w  (eff_w),
		.eff_h  (eff_h),
		.q_full (q_full),
		.q_push (q_push),
		.q_item (push_item)
	);

	blt_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.pop       (q_pop),
		.pop_item  (pop_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	blt_be u_be (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_item  (pop_item),
		.q_pop   (q_pop),
		.mode    (mode_q),
		.key     (key_q),
		.tint    (tint_q),
		.rsp     (rsp)
	);

endmodule

// ----- tb/tb_clipped_keyed_tinted_blitter_core.sv -----
// ----------------------------------------------------------------------------
// tb_clipped_keyed_tinted_blitter_core
// Self-checking bench for the blitter pixel engine. Start and pixel items go
// in through a bursty driver while the result side stalls on its own pattern.
// A local raster model tracks cursor, clipping, key and tint across several
// surface and mode settings, and every result item is checked field by field.
// ----------------------------------------------------------------------------
module tb_clipped_keyed_tinted_blitter_core
	import blt_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_DIM   = DEF_MAX_SURFACE_DIM;
	localparam int HOLD_LEN  = 300;
	localparam int DRAIN_GAP = 8;

	typedef struct packed {
		logic                      cmd;
		logic signed [COORD_W-1:0] ox;
		logic signed [COORD_W-1:0] oy;
		logic [DIM_W-1:0]          rw;
		logic [DIM_W-1:0]          rh;
		logic [COLOR_W-1:0]        pix;
	} blit_req_t;

	typedef struct packed {
		logic               we;
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] color;
		logic               done;
		logic               excess;
	} px_write_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	blt_in_if  req_ch ();
	blt_out_if rsp_ch ();

	clipped_keyed_tinted_blitter_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// raster model: registers and cursor state
	logic [DIM_W-1:0]          surf_w, surf_h;
	logic [1:0]                blend;
	logic [COLOR_W-1:0]        key_col, tint_col;
	logic signed [COORD_W-1:0] org_x, org_y;
	int                        span_w, span_h, col_pos, row_pos;
	logic [39:0]               row_base;
	bit                        rgn_active;

	blit_req_t pending_items[$];
	px_write_t expected_writes[$];
	blit_req_t on_bus;
	px_write_t next_write, want;
	bit        taken;
	int        mismatches;
	int        burst_left, gap_left;
	int        pat_kind, pat_left;
	bit        hold_rsp_req;
	int        hold_cnt;
	int        open_left;

	function automatic int clamp_dim(logic [DIM_W-1:0] v);
		return (int'(v) > MAX_DIM) ? MAX_DIM : int'(v);
	endfunction

	function automatic logic [CH_W-1:0] shade(logic [CH_W-1:0] c, logic [CH_W-1:0] t);
		logic [2*CH_W-1:0] p;
		p = c * t;
		return p[2*CH_W-1:CH_W];
	endfunction

	function void load_row_base();
		longint yy;
		yy = longint'(org_y) + longint'(row_pos);
		row_base = 40'(yy * longint'(clamp_dim(surf_w)));
	endfunction

	function void reset_model();
		surf_w     = RST_SURF_W;
		surf_h     = RST_SURF_H;
		blend      = MODE_COPY;
		key_col    = '0;
		tint_col   = RST_TINT;
		org_x      = '0;
		org_y      = '0;
		span_w     = 0;
		span_h     = 0;
		col_pos    = 0;
		row_pos    = 0;
		row_base   = '0;
		rgn_active = 0;
	endfunction

	function bit rasterize_item(input blit_req_t it, output px_write_t r);
		int                 x, y;
		logic [COLOR_W-1:0] c;
		bit                 ins, keyed;
		r = '0;
		if (it.cmd == CMD_START) begin
			org_x      = it.ox;
			org_y      = it.oy;
			span_w     = it.rw;
			span_h     = it.rh;
			col_pos    = 0;
			row_pos    = 0;
			load_row_base();
			rgn_active = span_w != 0 && span_h != 0;
			return 0;
		end
		if (!rgn_active) begin
			r.excess = 1'b1;
			return 1;
		end
		x   = int'(org_x) + col_pos;
		y   = int'(org_y) + row_pos;
		ins = x >= 0 && y >= 0 && x < clamp_dim(surf_w) && y < clamp_dim(surf_h);
		c   = it.pix;
		if (blend[TINT_BIT])
			c = {it.pix[31:24], shade(it.pix[23:16], tint_col[23:16]),
				shade(it.pix[15:8], tint_col[15:8]), shade(it.pix[7:0], tint_col[7:0])};
		keyed   = blend != MODE_COPY && it.pix == key_col;
		r.we    = ins && !keyed;
		r.addr  = ins ? ADDR_W'(row_base + 40'(x)) : '0;
		r.color = c;
		r.done  = (col_pos + 1 >= span_w) && (row_pos + 1 >= span_h);
		col_pos++;
		if (col_pos >= span_w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= span_h) begin
				rgn_active = 0;
				row_pos    = 0;
			end
			load_row_base();
		end
		return 1;
	endfunction

	always #5 clk = ~clk;

	// accept side of the input channel
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready) begin
			if (rasterize_item(on_bus, next_write))
				expected_writes.push_back(next_write);
			taken = 1;
		end
	end

	// driver: bursts of items with random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || taken) begin
			taken = 0;
			if (gap_left > 0) begin
				gap_left--;
				req_ch.valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				on_bus = pending_items.pop_front();
				req_ch.cmd           <= on_bus.cmd;
				req_ch.origin_x      <= on_bus.ox;
				req_ch.origin_y      <= on_bus.oy;
				req_ch.region_width  <= on_bus.rw;
				req_ch.region_height <= on_bus.rh;
				req_ch.source_pixel  <= on_bus.pix;
				req_ch.valid         <= 1'b1;
				if (burst_left == 0)
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
						: $urandom_range(1, 12);
				burst_left--;
				if (burst_left == 0)
					gap_left = $urandom_range(0, 6);
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// result side stall pattern, plus one long hold-off on request
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (hold_rsp_req && hold_cnt < HOLD_LEN) begin
			hold_cnt++;
			rsp_ch.ready <= 1'b0;
		end else begin
			if (pat_left == 0) begin
				pat_kind = $urandom_range(0, 3);
				pat_left = $urandom_range(20, 200);
			end
			pat_left--;
			case (pat_kind)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= $urandom_range(0, 1);
				2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
				default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	task automatic check_field(string fname, logic [31:0] e, logic [31:0] g);
		if (e !== g) begin
			mismatches++;
			$display("%0t mismatch %s: expected %h actual %h", $time, fname, e, g);
		end
	endtask

	// monitor
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_writes.size() == 0) begin
				mismatches++;
				$display("%0t unexpected item: expected none actual addr %h color %h",
					$time, rsp_ch.dest_address, rsp_ch.dest_color);
			end else begin
				want = expected_writes.pop_front();
				check_field("write_enable", want.we, rsp_ch.write_enable);
				check_field("dest_address", want.addr, rsp_ch.dest_address);
				check_field("dest_color", want.color, rsp_ch.dest_color);
				check_field("region_done", want.done, rsp_ch.region_done);
				check_field("excess_pixel", want.excess, rsp_ch.excess_pixel);
			end
		end
	end

	task automatic push_start(int ox, int oy, int w, int h);
		blit_req_t it;
		it     = '0;
		it.cmd = CMD_START;
		it.ox  = COORD_W'(ox);
		it.oy  = COORD_W'(oy);
		it.rw  = DIM_W'(w);
		it.rh  = DIM_W'(h);
		it.pix = $urandom;
		pending_items.push_back(it);
	endtask

	task automatic push_pix(logic [COLOR_W-1:0] p);
		blit_req_t it;
		it     = '0;
		it.cmd = CMD_PIXEL;
		it.ox  = COORD_W'($urandom);
		it.oy  = COORD_W'($urandom);
		it.pix = p;
		pending_items.push_back(it);
	endtask

	function automatic logic [COLOR_W-1:0] pick_color();
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4: return key_col;
			5: return '0;
			6: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic int near_edge(int extent, int span);
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, span + 2) - span - 1;
			1: return extent - $urandom_range(0, span + 1);
			2: return $urandom_range(0, extent);
			default: return int'($signed(COORD_W'($urandom)));
		endcase
	endfunction

	task automatic settle();
		while (pending_items.size() != 0 || req_ch.valid || expected_writes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic cfg_write(blt_cfg_e idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		case (idx)
			CFG_SURF_W: surf_w   = val[DIM_W-1:0];
			CFG_SURF_H: surf_h   = val[DIM_W-1:0];
			CFG_MODE:   blend    = val[1:0];
			CFG_KEY:    key_col  = val;
			CFG_TINT:   tint_col = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic cfg_all(int w, int h, logic [1:0] m, logic [31:0] k, logic [31:0] t);
		settle();
		cfg_write(CFG_SURF_W, w);
		cfg_write(CFG_SURF_H, h);
		cfg_write(CFG_MODE, 32'(m));
		cfg_write(CFG_KEY, k);
		cfg_write(CFG_TINT, t);
	endtask

	task automatic run_phase(int n_items);
		int sent, kind, w, h, n, ex, ey, since_pause;
		sent        = 0;
		since_pause = 0;
		// finish the region left open by the previous phase
		repeat (open_left) push_pix(pick_color());
		sent += open_left;
		while (sent < n_items) begin
			ex   = clamp_dim(surf_w);
			ey   = clamp_dim(surf_h);
			kind = $urandom_range(0, 99);
			if (kind < 72) begin
				w = $urandom_range(1, 6);
				h = $urandom_range(1, 4);
				if ($urandom_range(0, 9) == 0) begin
					w = $urandom_range(7, 48);
					h = 1;
				end
				n = w * h + (($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
				push_start(near_edge(ex, w), near_edge(ey, h), w, h);
			end else if (kind < 82) begin
				w = $urandom_range(1, 8);
				h = $urandom_range(1, 8);
				n = $urandom_range(0, w * h - 1);
				push_start(near_edge(ex, w), near_edge(ey, h), w, h);
			end else if (kind < 90) begin
				w = $urandom_range(0, 1) ? 0 : $urandom_range(0, MAX_DIM);
				h = (w == 0) ? $urandom_range(0, MAX_DIM) : 0;
				n = $urandom_range(1, 3);
				push_start(near_edge(ex, 2), near_edge(ey, 2), w, h);
			end else if (kind < 95) begin
				w = $urandom_range(0, 1) ? MAX_DIM : $urandom_range(1, MAX_DIM);
				h = $urandom_range(0, 1) ? MAX_DIM : $urandom_range(1, MAX_DIM);
				n = $urandom_range(1, 12);
				push_start(int'($signed(COORD_W'($urandom))),
					int'($signed(COORD_W'($urandom))), w, h);
			end else begin
				n = $urandom_range(1, 4);
				sent--;
			end
			repeat (n) push_pix(pick_color());
			sent        += n + 1;
			since_pause += n + 1;
			if (since_pause > 60 && $urandom_range(0, 2) == 0) begin
				settle();
				since_pause = 0;
			end
		end
		// leave a region open across the next register change
		push_start(near_edge(clamp_dim(surf_w), 5), near_edge(clamp_dim(surf_h), 4), 5, 4);
		repeat (7) push_pix(pick_color());
		open_left = 13;
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_SURF_W;
		cfg_data      = '0;
		req_ch.valid  = 1'b0;
		req_ch.cmd    = CMD_START;
		req_ch.origin_x      = '0;
		req_ch.origin_y      = '0;
		req_ch.region_width  = '0;
		req_ch.region_height = '0;
		req_ch.source_pixel  = '0;
		rsp_ch.ready  = 1'b0;
		taken         = 0;
		mismatches    = 0;
		burst_left    = 0;
		gap_left      = 0;
		pat_kind      = 0;
		pat_left      = 0;
		hold_rsp_req  = 0;
		hold_cnt      = 0;
		open_left     = 0;
		reset_model();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// straddles the top-left corner, then a lone pixel with no region
		push_start(-1, -1, 3, 2);
		push_pix(32'h0000_0000);
		push_pix(32'hffff_ffff);
		push_pix(32'h1234_5678);
		push_pix(32'ha5a5_a5a5);
		push_pix(32'h8000_0001);
		push_pix(32'h00ff_00ff);
		push_pix(32'hdead_beef);
		// extreme origin and size, abandoned by the next start
		push_start(32767, -32768, MAX_DIM, MAX_DIM);
		push_pix(32'h0102_0304);
		push_pix(32'hfffe_fdfc);
		// empty region: its pixel is excess
		push_start(318, 239, 0, 5);
		push_pix(32'h5555_aaaa);
		// bottom-right corner of the default surface
		push_start(318, 239, 2, 1);
		push_pix(32'h7f7f_7f7f);
		push_pix(32'h8080_8080);

		cfg_all(RST_SURF_W, RST_SURF_H, MODE_KEY, 32'h1234_5678, RST_TINT);
		push_start(0, 0, 2, 1);
		push_pix(32'h1234_5678);
		push_pix(32'h1234_5679);

		cfg_all(RST_SURF_W, RST_SURF_H, MODE_TINT, 32'h1234_5678, 32'h80ff_4001);
		push_start(100, 100, 1, 2);
		push_pix(32'hc0ff_8040);
		push_pix(32'h1234_5678);

		// mode three behaves as keyed and tinted
		cfg_all(RST_SURF_W, RST_SURF_H, MODE_KEY | MODE_TINT, 32'hffff_ffff, 32'h00ff_7f80);
		push_start(5, 5, 2, 1);
		push_pix(32'hffff_ffff);
		push_pix(32'h40c0_ff01);

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: cfg_all(1, 1, MODE_COPY, 32'h0, 32'h0);
				1: cfg_all(MAX_DIM, MAX_DIM, MODE_KEY, $urandom, 32'hffff_ffff);
				2: cfg_all(8191, 0, MODE_TINT, $urandom, $urandom);
				3: cfg_all(37, 13, MODE_KEY | MODE_TINT, $urandom, $urandom);
				4: cfg_all(0, 8191, MODE_KEY, $urandom, $urandom);
				5: cfg_all(64, MAX_DIM, MODE_TINT, 32'hffff_ffff, 32'hffff_ffff);
				default: cfg_all(MAX_DIM, 1, MODE_COPY, $urandom, $urandom);
			endcase
			if (ph == 1)
				hold_rsp_req = 1;
			run_phase(235);
		end

		settle();
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- clipped_keyed_tinted_blitter_core.f -----
rtl/blt_pkg.sv
rtl/blt_in_if.sv
rtl/blt_out_if.sv
rtl/blt_fe.sv
rtl/blt_fifo.sv
rtl/blt_be.sv
rtl/clipped_keyed_tinted_blitter_core.sv
tb/tb_clipped_keyed_tinted_blitter_core.sv
